### hw/rtl/kts_pkg.sv
// Shared constants, types and functions of the keyed top-K sorted table.
package kts_pkg;

	localparam int unsigned KTS_TABLE_DEPTH = 32;
	localparam int unsigned KTS_KEY_BYTES   = 8;
	localparam int unsigned KTS_TABLE_COUNT = 2;

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned ENTRY_W = KEY_W + SCORE_W;

	localparam logic MODE_SUBMIT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_NOTBETTER = 3'd1;
	localparam logic [2:0] ST_BELOW     = 3'd2;
	localparam logic [2:0] ST_READ_OK   = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         count;
		logic [4:0]         position;
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
	} kts_res_t;

	// Keeps the name bytes up to the first zero byte and within the key length.
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k,
			input int unsigned nbytes);
		logic [KEY_W-1:0] r;
		logic             stop;
		r    = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b >= nbytes || k[8*b +: 8] == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[8*b +: 8] = k[8*b +: 8];
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/kts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/kts_ctrl.sv
// Sequencer that scans, shifts, writes and reads back the table entries held in the RAM.
module kts_ctrl #(
	parameter int unsigned TABLE_DEPTH = kts_pkg::KTS_TABLE_DEPTH,
	parameter int unsigned KEY_BYTES   = kts_pkg::KTS_KEY_BYTES,
	parameter int unsigned TABLE_COUNT = kts_pkg::KTS_TABLE_COUNT,
	localparam int unsigned AW = $clog2(TABLE_COUNT * TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_mode,
	input  logic                          in_table,
	input  logic [kts_pkg::KEY_W-1:0]     in_key,
	input  logic [kts_pkg::SCORE_W-1:0]   in_score,
	input  logic [4:0]                    in_ridx,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [kts_pkg::ENTRY_W-1:0]   ram_wdata,
	output logic                          ram_re,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [kts_pkg::ENTRY_W-1:0]   ram_rdata,
	output logic                          res_valid,
	input  logic                          res_ready,
	output kts_pkg::kts_res_t             res
);
	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
	localparam int unsigned RW = (CW > 5) ? CW : 5;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_SHIFT  = 8'b0000_1000,
		S_WRITE  = 8'b0001_0000,
		S_RISSUE = 8'b0010_0000,
		S_RDATA  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} kts_state_t;

	kts_state_t                  st_q;
	logic [TW-1:0]               tbl_q;
	logic [AW-1:0]               base_q;
	logic [kts_pkg::KEY_W-1:0]   key_q;
	logic [kts_pkg::SCORE_W-1:0] score_q;
	logic [4:0]                  ridx_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               idx_q;
	logic                        rd_pend_s1;
	logic [IW-1:0]               rd_idx_s1;
	logic                        match_q;
	logic [IW-1:0]               mpos_q;
	logic [kts_pkg::SCORE_W-1:0] mscore_q;
	logic                        pfound_q;
	logic [IW-1:0]               pos_q;
	logic [CW-1:0]               sh_left_q;
	logic [IW-1:0]               sh_rd_q;
	logic [CW-1:0]               nc_q;
	logic [CW-1:0]               fill_q [TABLE_COUNT];
	kts_pkg::kts_res_t           res_q;

	logic [TW-1:0]               t_in;
	logic                        accept;
	logic [kts_pkg::KEY_W-1:0]   rd_key;
	logic [kts_pkg::SCORE_W-1:0] rd_score;
	logic [IW-1:0]               rd_addr_idx;
	logic [CW-1:0]               p_c;
	logic [CW-1:0]               nc_c;
	logic [CW-1:0]               wend_c;

	assign t_in     = (TABLE_COUNT > 1) ? TW'(in_table) : '0;
	assign in_ready = (st_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_key   = ram_rdata[kts_pkg::KEY_W-1:0];
	assign rd_score = ram_rdata[kts_pkg::ENTRY_W-1:kts_pkg::KEY_W];
	assign res_valid = (st_q == S_DONE);
	assign res       = res_q;

	assign p_c    = pfound_q ? CW'(pos_q) : cnt_q;
	assign nc_c   = match_q ? cnt_q :
			((cnt_q == CW'(TABLE_DEPTH)) ? cnt_q : CW'(cnt_q + 1'b1));
	assign wend_c = match_q ? CW'(mpos_q) : CW'(nc_c - 1'b1);

	always_comb begin
		ram_re      = 1'b0;
		rd_addr_idx = idx_q[IW-1:0];
		case (st_q)
			S_SCAN: begin
				ram_re      = (idx_q < cnt_q);
				rd_addr_idx = idx_q[IW-1:0];
			end
			S_SHIFT: begin
				ram_re      = (sh_left_q != '0);
				rd_addr_idx = sh_rd_q;
			end
			S_RISSUE: begin
				ram_re      = 1'b1;
				rd_addr_idx = IW'(ridx_q);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end
	assign ram_raddr = AW'(base_q + AW'(rd_addr_idx));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(base_q + AW'(IW'(rd_idx_s1 + 1'b1)));
		ram_wdata = ram_rdata;
		case (st_q)
			S_SHIFT: begin
				ram_we = rd_pend_s1;
			end
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(base_q + AW'(pos_q));
				ram_wdata = {score_q, key_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			rd_pend_s1 <= 1'b0;
			for (int i = 0; i < TABLE_COUNT; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			rd_pend_s1 <= ram_re;
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						if (in_mode == kts_pkg::MODE_READ) begin
							if (RW'(in_ridx) < RW'(fill_q[t_in])) begin
								st_q <= S_RISSUE;
							end else begin
								st_q <= S_DONE;
							end
						end else begin
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == cnt_q && !rd_pend_s1) begin
						st_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (match_q && score_q <= mscore_q) begin
						st_q <= S_DONE;
					end else if (!match_q && p_c == CW'(TABLE_DEPTH)) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (sh_left_q == '0 && !rd_pend_s1) begin
						st_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					fill_q[tbl_q] <= nc_q;
					st_q          <= S_DONE;
				end
				S_RISSUE: begin
					st_q <= S_RDATA;
				end
				S_RDATA: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_idx_s1 <= rd_addr_idx;
		end
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					tbl_q    <= t_in;
					base_q   <= AW'(AW'(t_in) * AW'(TABLE_DEPTH));
					key_q    <= kts_pkg::norm_key(in_key, KEY_BYTES);
					score_q  <= in_score;
					ridx_q   <= in_ridx;
					cnt_q    <= fill_q[t_in];
					idx_q    <= '0;
					match_q  <= 1'b0;
					pfound_q <= 1'b0;
					res_q.status   <= kts_pkg::ST_RANGE;
					res_q.count    <= 6'(fill_q[t_in]);
					res_q.position <= '0;
					res_q.key      <= '0;
					res_q.score    <= '0;
				end
			end
			S_SCAN: begin
				if (ram_re) begin
					idx_q <= CW'(idx_q + 1'b1);
				end
				if (rd_pend_s1) begin
					if (!match_q && rd_key == key_q) begin
						match_q  <= 1'b1;
						mpos_q   <= rd_idx_s1;
						mscore_q <= rd_score;
					end
					if (!pfound_q && score_q > rd_score) begin
						pfound_q <= 1'b1;
						pos_q    <= rd_idx_s1;
					end
				end
			end
			S_DECIDE: begin
				res_q.count <= 6'(cnt_q);
				if (match_q && score_q <= mscore_q) begin
					res_q.status <= kts_pkg::ST_NOTBETTER;
				end else begin
					res_q.status <= kts_pkg::ST_BELOW;
				end
				pos_q     <= IW'(p_c);
				nc_q      <= nc_c;
				sh_left_q <= CW'(wend_c - p_c);
				sh_rd_q   <= IW'(wend_c - 1'b1);
			end
			S_SHIFT: begin
				if (ram_re) begin
					sh_left_q <= CW'(sh_left_q - 1'b1);
					sh_rd_q   <= IW'(sh_rd_q - 1'b1);
				end
			end
			S_WRITE: begin
				res_q.status   <= kts_pkg::ST_INSERTED;
				res_q.count    <= 6'(nc_q);
				res_q.position <= 5'(pos_q);
			end
			S_RDATA: begin
				res_q.status   <= kts_pkg::ST_READ_OK;
				res_q.position <= ridx_q;
				res_q.key      <= rd_key;
				res_q.score    <= rd_score;
			end
			default: begin
			end
		endcase
	end
endmodule

### hw/rtl/keyed_top_k_sorted_table.sv
// Top level of the keyed top-K sorted table: RAM, sequencer and output register.
//
//  Channel  Dir  Data                                          Side band
//  s_*      in   table_sel, player_key, new_score, read_index  tuser: mode
//  m_*      out  entry_count, position, entry_key, entry_score tuser: status
//
// A read of a filled position issues one RAM read and returns the entry. A submit scans
// the table, one RAM read per entry, then moves the entries below the insert point one per
// cycle through the RAM read and write ports, and then writes the new entry.
// Reset clears the fill counts and the control state; entries are not cleared.
// A result waits in the output register while the next request is taken.
module keyed_top_k_sorted_table #(
	parameter int unsigned TABLE_DEPTH = kts_pkg::KTS_TABLE_DEPTH,
	parameter int unsigned KEY_BYTES   = kts_pkg::KTS_KEY_BYTES,
	parameter int unsigned TABLE_COUNT = kts_pkg::KTS_TABLE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// table_sel[0], player_key[64:1], new_score[80:65], read_index[85:81], zero[87:86]
	input  logic [87:0] s_tdata,
	// mode[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// entry_count[5:0], position[10:6], entry_key[74:11], entry_score[90:75], zero[95:91]
	output logic [95:0] m_tdata,
	// status[2:0]
	output logic [2:0]  m_tuser
);
	localparam int unsigned AW = $clog2(TABLE_COUNT * TABLE_DEPTH);

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [kts_pkg::ENTRY_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [kts_pkg::ENTRY_W-1:0] ram_rdata;
	logic                        res_valid;
	logic                        res_ready;
	kts_pkg::kts_res_t           res;
	logic                        out_valid_q;
	kts_pkg::kts_res_t           out_q;

	kts_ram #(
		.WIDTH(kts_pkg::ENTRY_W),
		.DEPTH(TABLE_COUNT * TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	kts_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BYTES(KEY_BYTES),
		.TABLE_COUNT(TABLE_COUNT)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_mode(s_tuser[0]),
		.in_table(s_tdata[0]),
		.in_key(s_tdata[64:1]),
		.in_score(s_tdata[80:65]),
		.in_ridx(s_tdata[85:81]),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'd0, out_q.score, out_q.key, out_q.position, out_q.count};

	a_res_reaches_port: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> m_tvalid)
		else $error("result not presented after handoff");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= kts_pkg::ST_RANGE))
		else $error("illegal status code");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");
endmodule

### tb/tb.sv
// Self-checking testbench for the keyed top-K sorted table: directed table plus random requests.
`timescale 1ns / 1ps

module tb;
	import kts_pkg::*;

	localparam int DEPTH = KTS_TABLE_DEPTH;
	localparam int NTAB  = KTS_TABLE_COUNT;
	localparam int N_RANDOM = 1200;

	typedef struct packed {
		logic        mode;
		logic        tsel;
		logic [63:0] key;
		logic [15:0] score;
		logic [4:0]  index;
	} board_req_t;

	typedef struct {
		board_req_t req;
		logic       has_exp;
		kts_res_t   exp;
	} board_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;

	logic [63:0] board_keys [NTAB][DEPTH];
	logic [15:0] board_scores [NTAB][DEPTH];
	int          board_fill [NTAB];
	kts_res_t    expected_results [$];
	int          error_count = 0;
	int          results_seen = 0;
	int          inserts_seen = 0;
	int          reads_seen = 0;
	board_row_t  directed [$];
	logic [63:0] name_pool [16];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	keyed_top_k_sorted_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic logic [63:0] trim_name(logic [63:0] k);
		logic [63:0] r;
		logic        stop;
		r = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b >= KTS_KEY_BYTES || k[8*b +: 8] == 8'd0) stop = 1'b1;
			if (!stop) r[8*b +: 8] = k[8*b +: 8];
		end
		return r;
	endfunction

	function automatic kts_res_t predict_leaderboard(board_req_t r);
		kts_res_t    res;
		int          t, cnt, pos, nc;
		logic [63:0] k;
		bit          rejected;
		res = '0;
		t = r.tsel % NTAB;
		cnt = board_fill[t];
		k = trim_name(r.key);
		rejected = 1'b0;
		if (r.mode == MODE_READ) begin
			if (r.index < cnt) begin
				res.status = ST_READ_OK;
				res.position = r.index;
				res.key = board_keys[t][r.index];
				res.score = board_scores[t][r.index];
			end else begin
				res.status = ST_RANGE;
			end
		end else begin
			for (int i = 0; i < cnt; i++) begin
				if (board_keys[t][i] == k) begin
					if (r.score <= board_scores[t][i]) begin
						rejected = 1'b1;
					end else begin
						for (int j = i; j + 1 < cnt; j++) begin
							board_keys[t][j] = board_keys[t][j+1];
							board_scores[t][j] = board_scores[t][j+1];
						end
						cnt--;
					end
					break;
				end
			end
			if (rejected) begin
				res.status = ST_NOTBETTER;
			end else begin
				pos = cnt;
				for (int i = 0; i < cnt; i++) begin
					if (r.score > board_scores[t][i]) begin
						pos = i;
						break;
					end
				end
				if (pos >= DEPTH) begin
					res.status = ST_BELOW;
					board_fill[t] = cnt;
				end else begin
					nc = cnt < DEPTH ? cnt + 1 : DEPTH;
					for (int i = nc - 1; i > pos; i--) begin
						board_keys[t][i] = board_keys[t][i-1];
						board_scores[t][i] = board_scores[t][i-1];
					end
					board_keys[t][pos] = k;
					board_scores[t][pos] = r.score;
					board_fill[t] = nc;
					res.status = ST_INSERTED;
					res.position = 5'(pos);
				end
			end
		end
		res.count = 6'(board_fill[t]);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
		error_count++;
	endtask

	// Requests are spaced by an idle gap so valid drops between them.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
		if ($urandom_range(0, 3) == 0) n = 1;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(board_req_t r, logic has_exp, kts_res_t exp);
		kts_res_t p;
		idle_gap();
		p = predict_leaderboard(r);
		if (has_exp && p != exp) begin
			report_mismatch("directed row vs predictor",
				64'({p.status, p.count, p.position, p.score}),
				64'({exp.status, exp.count, exp.position, exp.score}));
		end
		expected_results.push_back(p);
		if (p.status == ST_INSERTED) inserts_seen++;
		if (p.status == ST_READ_OK) reads_seen++;
		s_tdata <= {2'b00, r.index, r.score, r.key, r.tsel};
		s_tuser <= r.mode;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
	endtask

	function automatic board_req_t random_request();
		board_req_t r;
		r.mode = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_SUBMIT;
		r.tsel = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) == 0) r.key = {$urandom, $urandom};
		else r.key = name_pool[$urandom_range(0, 15)];
		case ($urandom_range(0, 3))
			0: r.score = 16'($urandom);
			1: r.score = 16'($urandom_range(0, 40));
			2: r.score = 16'hFFFF - 16'($urandom_range(0, 3));
			default: r.score = 16'($urandom_range(100, 400));
		endcase
		r.index = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 8));
		return r;
	endfunction

	function automatic board_row_t row(logic mode, logic tsel, logic [63:0] key,
			logic [15:0] score, logic [4:0] index, logic has_exp, logic [2:0] st,
			logic [5:0] cnt, logic [4:0] pos, logic [63:0] ekey, logic [15:0] escore);
		board_row_t b;
		b.req = '{mode, tsel, key, score, index};
		b.has_exp = has_exp;
		b.exp = '{st, cnt, pos, ekey, escore};
		return b;
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			kts_res_t got, want;
			got = '{m_tuser, m_tdata[5:0], m_tdata[10:6], m_tdata[74:11], m_tdata[90:75]};
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(got.status), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) report_mismatch("status", got.status, want.status);
				if (got.count !== want.count) report_mismatch("entry_count", got.count, want.count);
				if (got.position !== want.position)
					report_mismatch("position", got.position, want.position);
				if (got.key !== want.key) report_mismatch("entry_key", got.key, want.key);
				if (got.score !== want.score) report_mismatch("entry_score", got.score, want.score);
				if (m_tdata[95:91] !== 5'd0) report_mismatch("pad bits", m_tdata[95:91], 0);
			end
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 15) == 0) m_tready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
		else if (!m_tready) m_tready <= $urandom_range(0, 4) == 0;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		kts_res_t    none;
		for (int t = 0; t < NTAB; t++) board_fill[t] = 0;
		for (int i = 0; i < 16; i++) name_pool[i] = {$urandom, $urandom};
		name_pool[0] = 64'h41;
		name_pool[1] = 64'h4241;
		name_pool[2] = 64'hFF00_0000_0000_4241;
		name_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
		name_pool[4] = 64'h0;
		none = '0;

		directed.push_back(row(MODE_READ, 0, 0, 0, 0, 1, ST_RANGE, 0, 0, 0, 0));
		directed.push_back(row(MODE_READ, 1, '1, '1, 31, 1, ST_RANGE, 0, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, 64'h4241, 16'd100, 0, 1, ST_INSERTED, 1, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, 64'hAA00_0000_0000_4241, 16'd50, 0,
			1, ST_NOTBETTER, 1, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, 64'h4241, 16'd100, 0, 1, ST_NOTBETTER, 1, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, 64'hFF00_0000_0000_4241, 16'd200, 0,
			1, ST_INSERTED, 1, 0, 0, 0));
		directed.push_back(row(MODE_READ, 0, 0, 0, 0, 1, ST_READ_OK, 1, 0, 64'h4241, 16'd200));
		directed.push_back(row(MODE_SUBMIT, 0, 64'h43, 16'd200, 0, 1, ST_INSERTED, 2, 1, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, '1, 16'hFFFF, 0, 1, ST_INSERTED, 3, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, 64'h0, 16'd0, 0, 1, ST_INSERTED, 4, 3, 0, 0));
		directed.push_back(row(MODE_READ, 0, 0, 0, 0, 1, ST_READ_OK, 4, 0, '1, 16'hFFFF));
		directed.push_back(row(MODE_READ, 0, 0, 0, 3, 1, ST_READ_OK, 4, 3, 0, 0));
		directed.push_back(row(MODE_READ, 0, 0, 0, 4, 1, ST_RANGE, 4, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 1, 64'h43, 16'd7, 0, 1, ST_INSERTED, 1, 0, 0, 0));
		directed.push_back(row(MODE_SUBMIT, 0, 64'h43, 16'd300, 0, 0, none.status, 0, 0, 0, 0));
		directed.push_back(row(MODE_READ, 0, 0, 0, 1, 0, none.status, 0, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_request(directed[i].req, directed[i].has_exp, directed[i].exp);

		// Fill table 1 past its depth with descending and tied scores, then test the end.
		for (int i = 0; i < DEPTH + 4; i++) begin
			board_req_t r;
			r = '{MODE_SUBMIT, 1'b1, {32'h5000 + i, 32'h0101_0101}, 16'd1000 - 16'(i / 2), 5'd0};
			send_request(r, 0, none);
		end
		send_request('{MODE_SUBMIT, 1'b1, 64'h7777, 16'd1, 5'd0}, 1,
			'{ST_BELOW, 6'd32, 5'd0, 64'd0, 16'd0});
		send_request('{MODE_READ, 1'b1, 64'd0, 16'd0, 5'd31}, 0, none);

		wait (expected_results.size() == 0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) wait (expected_results.size() == 0);
			send_request(random_request(), 0, none);
		end

		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d results: %0d inserts, %0d successful reads, both tables filled.",
			results_seen, inserts_seen, reads_seen);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### keyed_top_k_sorted_table.f
hw/rtl/kts_pkg.sv
hw/rtl/kts_ram.sv
hw/rtl/kts_ctrl.sv
hw/rtl/keyed_top_k_sorted_table.sv
tb/tb.sv
